// ----- rtl/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared constants and types of the insertion sorter: store geometry,
// controller states and the memory request bundle.
// ----------------------------------------------------------------------------
package isrt_pkg;

  // Store geometry.
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT
  } state_t;

  // One cycle's access to the store: one write port and one read port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/isrt_ram.sv -----
// ----------------------------------------------------------------------------
// isrt_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module isrt_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/isrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// isrt_ctrl
// Sequencer of the insertion sorter. It shifts larger entries up one slot at
// a time while scanning down from the top, places the new value, and on the
// final request of a set streams the store out in ascending order.
// ----------------------------------------------------------------------------
module isrt_ctrl (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [isrt_pkg::DATA_W-1:0]     in_value,
  input  logic                                   in_last,
  output logic                                   out_valid,
  output logic signed [isrt_pkg::DATA_W-1:0]     out_value,
  output logic                                   out_last,
  output logic                                   out_overflow,
  output isrt_pkg::mem_req_t                     mem_req,
  input  logic [isrt_pkg::DATA_W-1:0]            mem_rdata
);

  localparam int ADDR_W = isrt_pkg::ADDR_W;
  localparam int CNT_W  = isrt_pkg::CNT_W;
  localparam int DATA_W = isrt_pkg::DATA_W;

  isrt_pkg::state_t          state_r, state_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic                      drop_r, drop_nxt;
  logic [ADDR_W-1:0]         pos_r, pos_nxt;
  logic [ADDR_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0]  val_r, val_nxt;
  logic                      last_r, last_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic                      olast_r, olast_nxt;
  logic                      oovf_r, oovf_nxt;
  logic                      take;
  logic                      fin;
  logic                      smaller;

  assign busy = (state_r != isrt_pkg::ST_IDLE);
  assign take = start && !busy;

  // The new value moves below an entry only if strictly smaller: stability.
  assign smaller = (val_r < $signed(mem_rdata));

  // The read issued at the last emission index marks the final result.
  assign fin = ((CNT_W'(idx_r) + CNT_W'(1)) == fill_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= isrt_pkg::ST_IDLE;
      fill_r   <= '0;
      drop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      drop_r   <= drop_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    last_r  <= last_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  // Next state, store accesses and result flags.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    ovalid_nxt    = 1'b0;
    olast_nxt     = 1'b0;
    oovf_nxt      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = pos_r;
    mem_req.wdata = val_r;
    mem_req.raddr = '0;

    unique case (state_r)
      isrt_pkg::ST_IDLE: begin
        if (take) begin
          val_nxt  = in_value;
          last_nxt = in_last;
          idx_nxt  = '0;
          if (fill_r == CNT_W'(isrt_pkg::CAPACITY)) begin
            // Store full: drop the value, still emit on a final request.
            drop_nxt = 1'b1;
            if (in_last) begin
              state_nxt = isrt_pkg::ST_EMIT;
            end
          end else if (fill_r == '0) begin
            // Empty store: the value goes straight to the bottom slot.
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = in_value;
            fill_nxt      = fill_r + CNT_W'(1);
            if (in_last) begin
              state_nxt = isrt_pkg::ST_EMIT;
            end
          end else begin
            // Start the downward scan at the top entry.
            mem_req.raddr = ADDR_W'(fill_r - CNT_W'(1));
            pos_nxt       = ADDR_W'(fill_r);
            state_nxt     = isrt_pkg::ST_SCAN;
          end
        end
      end

      isrt_pkg::ST_SCAN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        if (smaller) begin
          // Move the larger entry up one slot and read the next one down.
          mem_req.wdata = mem_rdata;
          pos_nxt       = pos_r - ADDR_W'(1);
          if (pos_r == ADDR_W'(1)) begin
            state_nxt = isrt_pkg::ST_PLACE;
          end else begin
            mem_req.raddr = pos_r - ADDR_W'(2);
          end
        end else begin
          // Found the slot just above an entry not larger than the value.
          mem_req.wdata = val_r;
          fill_nxt      = fill_r + CNT_W'(1);
          state_nxt     = last_r ? isrt_pkg::ST_EMIT : isrt_pkg::ST_IDLE;
        end
      end

      isrt_pkg::ST_PLACE: begin
        // The value is the smallest so far and lands at the bottom.
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = val_r;
        fill_nxt      = fill_r + CNT_W'(1);
        state_nxt     = last_r ? isrt_pkg::ST_EMIT : isrt_pkg::ST_IDLE;
      end

      isrt_pkg::ST_EMIT: begin
        // Read one entry a cycle; the result appears with the read data.
        mem_req.raddr = idx_r;
        ovalid_nxt    = 1'b1;
        olast_nxt     = fin;
        oovf_nxt      = fin && drop_r;
        if (fin) begin
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = isrt_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      default: begin
        state_nxt = isrt_pkg::ST_IDLE;
      end
    endcase
  end

  // Result ports, aligned with the registered read data.
  assign out_valid    = ovalid_r;
  assign out_value    = $signed(mem_rdata);
  assign out_last     = olast_r;
  assign out_overflow = oovf_r;

endmodule

// ----- rtl/insertion_sorter_top.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter_top
// A request into an empty or full store is taken in the idle state and
// raises busy only if final; otherwise busy holds while the downward scan
// moves larger entries up one per cycle through the store's single read
// port. One request at a time. After a final request the results follow
// the insert, one per cycle, one per stored value; results cannot stall.
// Reset clears the fill count, the dropped flag and the controller only.
// ----------------------------------------------------------------------------
module insertion_sorter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [isrt_pkg::DATA_W-1:0] in_value,
  input  logic                               in_last,
  output logic                               out_valid,
  output logic signed [isrt_pkg::DATA_W-1:0] out_value,
  output logic                               out_last,
  output logic                               out_overflow
);

  isrt_pkg::mem_req_t              mem_req;
  logic [isrt_pkg::DATA_W-1:0]     mem_rdata;

  // Sequencer.
  isrt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  // Sorted store.
  isrt_ram #(
    .DEPTH  (isrt_pkg::CAPACITY),
    .WIDTH  (isrt_pkg::DATA_W),
    .ADDR_W (isrt_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // The final flag and the overflow flag only ride on a result strobe.
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_last || out_overflow) |-> out_valid)
    else $error("last or overflow flag without a result strobe");

  // Overflow is reported on the final result only.
  a_ovf_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> out_last)
    else $error("overflow flag on a result that is not final");

  // Emission is one unbroken burst up to the final result.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside the result burst");

  // A result before the final one means the sequencer is still busy.
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("not busy while results are still pending");

endmodule
